FILE: rtl/core/mffd_pkg.sv
// Package for the motor feedback frame decoder.
// Holds the shared types, register indexes, status codes and frame constants.
// Depends on nothing; the decoder, register, check and unwrap modules import it.
package mffd_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_ENABLE         = 2'd0;
  localparam logic [1:0] REG_MOTOR_ID       = 2'd1;
  localparam logic [1:0] REG_ENCODER_COUNTS = 2'd2;

  localparam logic [28:0] BASE_IDENT  = 29'h200;
  localparam logic [6:0]  FRAME_BYTES = 7'd8;

  localparam logic [16:0] ENCODER_COUNTS_RESET = 17'd8192;
  localparam logic [3:0]  MOTOR_ID_RESET       = 4'd1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DISABLED  = 2'd1,
    STATUS_BAD_IDENT = 2'd2,
    STATUS_MALFORMED = 2'd3
  } status_t;

  typedef struct packed {
    logic        enable;
    logic [3:0]  motor_id;
    logic [16:0] encoder_counts;
  } cfg_t;

  typedef struct packed {
    logic [28:0] frame_ident;
    logic        extended_ident;
    logic        flexible_format;
    logic [6:0]  byte_count;
    logic [63:0] payload;
  } frame_t;

  typedef struct packed {
    status_t            status;
    logic [15:0]        rotor_position;
    logic signed [15:0] speed_rpm;
    logic signed [15:0] current_code;
    logic [7:0]         temperature;
    logic [7:0]         fault_code;
  } decoded_t;

  typedef struct packed {
    decoded_t           fields;
    logic signed [63:0] turn_count;
  } result_t;

endpackage

FILE: rtl/core/mffd_in_if.sv
// Input channel of the motor feedback frame decoder: one received bus frame
// per transaction. Depends on nothing.
interface mffd_in_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_ident;
  logic        extended_ident;
  logic        flexible_format;
  logic [6:0]  byte_count;
  logic [63:0] payload;

  modport source (
    output valid, frame_ident, extended_ident, flexible_format, byte_count, payload,
    input  ready
  );
  modport sink (
    input  valid, frame_ident, extended_ident, flexible_format, byte_count, payload,
    output ready
  );
endinterface

FILE: rtl/core/mffd_out_if.sv
// Result channel of the motor feedback frame decoder: one status result per
// transaction. Depends on nothing.
interface mffd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        rotor_position;
  logic signed [15:0] speed_rpm;
  logic signed [15:0] current_code;
  logic [7:0]         temperature;
  logic [7:0]         fault_code;
  logic signed [63:0] turn_count;

  modport source (
    output valid, status, rotor_position, speed_rpm, current_code, temperature,
           fault_code, turn_count,
    input  ready
  );
  modport sink (
    input  valid, status, rotor_position, speed_rpm, current_code, temperature,
           fault_code, turn_count,
    output ready
  );
endinterface

FILE: rtl/core/motor_feedback_frame_decoder.sv
// Motor feedback frame decoder: checks each received bus frame, unpacks the
// feedback fields and keeps a 64-bit multi-turn rotor count.
// Depends on mffd_pkg, mffd_in_if, mffd_out_if, mffd_cfg_regs,
// mffd_frame_check and mffd_unwrap.
//
// Each frame transaction gives one result transaction through an input register
// and then a result register; a new frame is taken every cycle, and the rate
// is one frame per cycle, held back only by the result sink.
// Rejected frames leave the count untouched and report zero in all fields but
// status. The user must write configuration over the APB port only while no
// frame is in flight; the block itself does not enforce this.
module motor_feedback_frame_decoder
  import mffd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  mffd_in_if.sink           frame_in,
  mffd_out_if.source        result_out
);

  cfg_t               cfg;
  frame_t             stage_frame;
  logic               stage_valid;
  logic               stage_move;
  decoded_t           decoded;
  logic               count_update;
  logic signed [63:0] total_next;
  result_t            result;
  logic               result_valid;
  logic               result_load;

  mffd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign result_load    = !result_valid || result_out.ready;
  assign stage_move     = stage_valid && result_load;
  assign frame_in.ready = !stage_valid || result_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (frame_in.ready) begin
      stage_valid <= frame_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_in.valid && frame_in.ready) begin
      stage_frame.frame_ident     <= frame_in.frame_ident;
      stage_frame.extended_ident  <= frame_in.extended_ident;
      stage_frame.flexible_format <= frame_in.flexible_format;
      stage_frame.byte_count      <= frame_in.byte_count;
      stage_frame.payload         <= frame_in.payload;
    end
  end

  mffd_frame_check u_frame_check (
    .frame   (stage_frame),
    .cfg     (cfg),
    .decoded (decoded)
  );

  assign count_update = stage_move && (decoded.status == STATUS_OK);

  mffd_unwrap u_unwrap (
    .clk            (clk),
    .rst            (rst),
    .update         (count_update),
    .position       (decoded.rotor_position),
    .encoder_counts (cfg.encoder_counts),
    .total_next     (total_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      result.fields     <= decoded;
      result.turn_count <= (decoded.status == STATUS_OK) ? total_next : 64'sd0;
    end
  end

  assign result_out.valid          = result_valid;
  assign result_out.status         = result.fields.status;
  assign result_out.rotor_position = result.fields.rotor_position;
  assign result_out.speed_rpm      = result.fields.speed_rpm;
  assign result_out.current_code   = result.fields.current_code;
  assign result_out.temperature    = result.fields.temperature;
  assign result_out.fault_code     = result.fields.fault_code;
  assign result_out.turn_count     = result.turn_count;

  a_rejected_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && (result_out.status != STATUS_OK) |->
      (result_out.turn_count == 64'sd0) && (result_out.rotor_position == 16'd0))
    else $error("Rejected frame result carries non-zero fields.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> frame_in.ready)
    else $error("Frame input stalled while the result register is empty.");

  a_position_passes: assert property (@(posedge clk) disable iff (rst)
    count_update |=> result_out.valid &&
      (result_out.rotor_position == $past(stage_frame.payload[63:48])))
    else $error("Accepted frame result lost its rotor position.");

endmodule

FILE: rtl/core/mffd_cfg_regs.sv
// APB-style configuration registers of the motor feedback frame decoder.
// Depends on mffd_pkg for the register indexes and the cfg_t type.
module mffd_cfg_regs
  import mffd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       regs;
  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable         <= 1'b0;
      regs.motor_id       <= MOTOR_ID_RESET;
      regs.encoder_counts <= ENCODER_COUNTS_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_ENABLE:         regs.enable         <= pwdata[0];
        REG_MOTOR_ID:       regs.motor_id       <= pwdata[3:0];
        REG_ENCODER_COUNTS: regs.encoder_counts <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ENABLE:         prdata = {{(DATA_W-1){1'b0}}, regs.enable};
      REG_MOTOR_ID:       prdata = {{(DATA_W-4){1'b0}}, regs.motor_id};
      REG_ENCODER_COUNTS: prdata = {{(DATA_W-17){1'b0}}, regs.encoder_counts};
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/mffd_frame_check.sv
// Frame check and payload unpacking of the motor feedback frame decoder.
// Depends on mffd_pkg for the frame, configuration and decoded types.
module mffd_frame_check
  import mffd_pkg::*;
(
  input  frame_t   frame,
  input  cfg_t     cfg,
  output decoded_t decoded
);

  logic [28:0] expected_ident;

  assign expected_ident = BASE_IDENT + {25'd0, cfg.motor_id};

  always_comb begin
    decoded = '0;
    if (!cfg.enable) begin
      decoded.status = STATUS_DISABLED;
    end else if (frame.frame_ident != expected_ident) begin
      decoded.status = STATUS_BAD_IDENT;
    end else if (frame.extended_ident || frame.flexible_format ||
                 frame.byte_count != FRAME_BYTES) begin
      decoded.status = STATUS_MALFORMED;
    end else begin
      decoded.status         = STATUS_OK;
      decoded.rotor_position = frame.payload[63:48];
      decoded.speed_rpm      = frame.payload[47:32];
      decoded.current_code   = frame.payload[31:16];
      decoded.temperature    = frame.payload[15:8];
      decoded.fault_code     = frame.payload[7:0];
    end
  end

endmodule

FILE: rtl/core/mffd_unwrap.sv
// Multi-turn unwrap of the rotor position: holds the last position and the
// 64-bit turn count. Depends on mffd_pkg.
module mffd_unwrap
  import mffd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               update,
  input  logic [15:0]        position,
  input  logic [16:0]        encoder_counts,
  output logic signed [63:0] total_next
);

  logic               seen_first;
  logic [15:0]        last_position;
  logic signed [63:0] total_count;

  logic signed [17:0] delta;
  logic signed [17:0] half;
  logic signed [18:0] delta_wide;
  logic signed [18:0] counts_wide;
  logic signed [18:0] step;

  assign delta       = $signed({2'b00, position}) - $signed({2'b00, last_position});
  assign half        = $signed({2'b00, encoder_counts[16:1]});
  assign delta_wide  = {delta[17], delta};
  assign counts_wide = $signed({2'b00, encoder_counts});

  always_comb begin
    if (delta > half) begin
      step = delta_wide - counts_wide;
    end else if (delta < -half) begin
      step = delta_wide + counts_wide;
    end else begin
      step = delta_wide;
    end
    if (!seen_first) begin
      total_next = $signed({48'd0, position});
    end else begin
      total_next = total_count + {{45{step[18]}}, step};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first    <= 1'b0;
      last_position <= '0;
      total_count   <= '0;
    end else if (update) begin
      seen_first    <= 1'b1;
      last_position <= position;
      total_count   <= total_next;
    end
  end

endmodule
